// ===== rtl/cfic_pkg.sv =====
// shared types, constants and helpers for the complex float / int16 converter
// no dependencies
package cfic_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegDirection   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSwapBytes   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegToPackedScl = 4'd2;
  localparam logic [CfgIdxW-1:0] RegToFloatScl  = 4'd3;

  // reset values of the scale registers
  localparam logic [31:0] ToPackedSclRst = 32'h46FF_FE00;
  localparam logic [31:0] ToFloatSclRst  = 32'h3800_0100;

  // float constants
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [15:0] IntInvalid = 16'h8000;
  localparam logic [15:0] IntMaxPos  = 16'h7FFF;

  // operand as value = man * 2^exp, with special classes
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [9:0]  exp;
    logic [23:0]        man;
  } fop_t;

  // per-stage load enables of the multiplier pipe
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic fop_t decode_f32(input logic [31:0] bits);
    fop_t o;
    o.sign = bits[31];
    o.nan  = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
    o.inf  = (bits[30:23] == 8'hFF) && (bits[22:0] == 23'd0);
    o.zero = (bits[30:0] == 31'd0);
    if (bits[30:23] == 8'd0) begin
      o.man = {1'b0, bits[22:0]};
      o.exp = -10'sd149;
    end else begin
      o.man = {1'b1, bits[22:0]};
      o.exp = $signed({2'b00, bits[30:23]}) - 10'sd150;
    end
    return o;
  endfunction

  function automatic fop_t decode_i16(input logic [15:0] h);
    fop_t o;
    logic [15:0] mag;
    mag    = h[15] ? (~h + 16'd1) : h;
    o.sign = h[15];
    o.nan  = 1'b0;
    o.inf  = 1'b0;
    o.zero = (h == 16'd0);
    o.exp  = 10'sd0;
    o.man  = {8'd0, mag};
    return o;
  endfunction

  function automatic logic [31:0] byte_rev(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/cfic_fmul.sv =====
// three-stage single-precision multiplier, round to nearest even, subnormals kept
// depends on cfic_pkg; any nan result comes out as the default nan
module cfic_fmul (
  input  logic                clk,
  input  cfic_pkg::stage_en_t en,
  input  cfic_pkg::fop_t      a,
  input  cfic_pkg::fop_t      b,
  output logic [31:0]         res
);

  // stage 1: significand product and exponent sum
  logic               nan1, inf1, zero1, sign1;
  logic signed [10:0] e1;
  logic [47:0]        prod1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sign1 <= a.sign ^ b.sign;
      nan1  <= a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
      inf1  <= a.inf | b.inf;
      zero1 <= a.zero | b.zero;
      e1    <= 11'(a.exp) + 11'(b.exp);
      prod1 <= a.man * b.man;
    end
  end

  // stage 2: leading one and shift amount
  logic [5:0]         lead;
  logic signed [10:0] r_a, r_b, r_max, r_clip;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod1[i]) lead = 6'(i);
    end
    r_a    = $signed({5'd0, lead}) - 11'sd23;
    r_b    = -11'sd149 - e1;
    r_max  = (r_a > r_b) ? r_a : r_b;
    r_clip = (r_max > 11'sd50) ? 11'sd50 : r_max;
  end

  logic               nan2, inf2, zero2, sign2;
  logic signed [10:0] r2, q2;
  logic [47:0]        prod2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sign2 <= sign1;
      nan2  <= nan1;
      inf2  <= inf1;
      zero2 <= zero1;
      r2    <= r_clip;
      q2    <= e1 + r_max;
      prod2 <= prod1;
    end
  end

  // stage 3: align, round and pack
  logic [97:0]        wide;
  logic [47:0]        lsh;
  logic [23:0]        s0;
  logic               guard, sticky;
  logic [24:0]        s_rnd;
  logic [23:0]        s_fin;
  logic signed [10:0] q_fin, e_bias;
  logic [31:0]        packed_f;

  always_comb begin
    wide   = {prod2, 50'd0} >> r2[5:0];
    lsh    = prod2 << 5'(-r2);
    if (r2 < 0) begin
      s0     = lsh[23:0];
      guard  = 1'b0;
      sticky = 1'b0;
    end else begin
      s0     = wide[73:50];
      guard  = wide[49];
      sticky = |wide[48:0];
    end
    s_rnd = {1'b0, s0} + {24'd0, guard & (sticky | s0[0])};
    if (s_rnd[24]) begin
      s_fin = s_rnd[24:1];
      q_fin = q2 + 11'sd1;
    end else begin
      s_fin = s_rnd[23:0];
      q_fin = q2;
    end
    e_bias = q_fin + 11'sd150;
    if (nan2) begin
      packed_f = cfic_pkg::DefaultNan;
    end else if (inf2 || (s_fin[23] && e_bias >= 11'sd255)) begin
      packed_f = {sign2, 8'hFF, 23'd0};
    end else if (zero2) begin
      packed_f = {sign2, 31'd0};
    end else if (s_fin[23]) begin
      packed_f = {sign2, e_bias[7:0], s_fin[22:0]};
    end else begin
      packed_f = {sign2, 8'd0, s_fin[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      res <= packed_f;
    end
  end

endmodule

// ===== rtl/cfic_f2i.sv =====
// float to int16: round to nearest even, saturate, nan or beyond int32 gives -32768
// depends on cfic_pkg
module cfic_f2i (
  input  logic [31:0] f,
  output logic [15:0] i16
);

  logic [7:0]  ex;
  logic [23:0] man;
  logic [4:0]  rsh;
  logic [48:0] ext;
  logic [23:0] ip;
  logic [31:0] mag;
  logic [31:0] neg;

  always_comb begin
    ex  = f[30:23];
    man = (ex == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
    rsh = (ex <= 8'd125) ? 5'd25 : 5'(8'd150 - ex);
    ext = {man, 25'd0} >> rsh;
    ip  = ext[48:25];
    // integer magnitude, exact above the binary point, rounded below it
    if (ex >= 8'd150) begin
      mag = {8'd0, man} << 3'(ex - 8'd150);
    end else begin
      mag = {8'd0, ip} + {31'd0, ext[24] & ((|ext[23:0]) | ip[0])};
    end
    neg = ~mag + 32'd1;
    if (ex >= 8'd158) begin
      i16 = cfic_pkg::IntInvalid;
    end else if (f[31]) begin
      i16 = (mag > 32'd32768) ? cfic_pkg::IntInvalid : neg[15:0];
    end else begin
      i16 = (mag > 32'd32767) ? cfic_pkg::IntMaxPos : mag[15:0];
    end
  end

endmodule

// ===== rtl/complex_float_int16_converter.sv =====
// top level: config registers, input register, two multiplier lanes, output register
// depends on cfic_pkg, cfic_fmul, cfic_f2i
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | real_in, imag_in, packed_in
//   out     | out_valid/ out_ready | packed_out, real_out, imag_out
//   cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one word per clock sustained while out_ready stays high; out_valid rises once the
// accepted word has passed the input register, the three multiplier stages and the
// output register. every stage holds its word only while the one after it is full
// and stalled, so input is taken as long as any stage has room.
// synchronous reset empties the pipe and loads the register defaults.
module complex_float_int16_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  real_in,
  input  logic [31:0]                  imag_in,
  input  logic [31:0]                  packed_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  packed_out,
  output logic [31:0]                  real_out,
  output logic [31:0]                  imag_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cfic_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  // configuration registers
  logic        direction, swap_bytes;
  logic [31:0] to_packed_scale, to_float_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction       <= 1'b0;
      swap_bytes      <= 1'b0;
      to_packed_scale <= cfic_pkg::ToPackedSclRst;
      to_float_scale  <= cfic_pkg::ToFloatSclRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfic_pkg::RegDirection:   direction       <= cfg_data[0];
        cfic_pkg::RegSwapBytes:   swap_bytes      <= cfg_data[0];
        cfic_pkg::RegToPackedScl: to_packed_scale <= cfg_data;
        cfic_pkg::RegToFloatScl:  to_float_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe occupancy and per-stage load enables
  logic [4:0] vld;
  logic [4:0] rdy;
  cfic_pkg::stage_en_t en;

  assign rdy[4] = !vld[4] || out_ready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];
  assign in_ready = rdy[0];
  assign en.s1 = rdy[1];
  assign en.s2 = rdy[2];
  assign en.s3 = rdy[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 5'd0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
    end
  end

  // input register
  logic [31:0] re0, im0, pk0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      re0 <= real_in;
      im0 <= imag_in;
      pk0 <= packed_in;
    end
  end

  // operand select per direction
  logic [31:0]     pk_host;
  cfic_pkg::fop_t  op_re, op_im, op_scl;

  always_comb begin
    pk_host = swap_bytes ? cfic_pkg::byte_rev(pk0) : pk0;
    if (direction) begin
      op_re  = cfic_pkg::decode_i16(pk_host[31:16]);
      op_im  = cfic_pkg::decode_i16(pk_host[15:0]);
      op_scl = cfic_pkg::decode_f32(to_float_scale);
    end else begin
      op_re  = cfic_pkg::decode_f32(re0);
      op_im  = cfic_pkg::decode_f32(im0);
      op_scl = cfic_pkg::decode_f32(to_packed_scale);
    end
  end

  // multiplier lanes
  logic [31:0] prod_re, prod_im;

  cfic_fmul u_mul_re (.clk(clk), .en(en), .a(op_re), .b(op_scl), .res(prod_re));
  cfic_fmul u_mul_im (.clk(clk), .en(en), .a(op_im), .b(op_scl), .res(prod_im));

  // integer conversion
  logic [15:0] int_re, int_im;

  cfic_f2i u_f2i_re (.f(prod_re), .i16(int_re));
  cfic_f2i u_f2i_im (.f(prod_im), .i16(int_im));

  // result select, in the unpacking direction a nan to-float scale passes through quieted
  logic [31:0] pk_word, re_word, im_word;
  logic        scl_nan;

  always_comb begin
    scl_nan = (to_float_scale[30:23] == 8'hFF) && (to_float_scale[22:0] != 23'd0);
    pk_word = swap_bytes ? cfic_pkg::byte_rev({int_re, int_im}) : {int_re, int_im};
    if (direction) begin
      pk_word = 32'd0;
      re_word = scl_nan ? (to_float_scale | cfic_pkg::QuietBit) : prod_re;
      im_word = scl_nan ? (to_float_scale | cfic_pkg::QuietBit) : prod_im;
    end else begin
      re_word = 32'd0;
      im_word = 32'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      packed_out <= pk_word;
      real_out   <= re_word;
      imag_out   <= im_word;
    end
  end

  assign out_valid = vld[4];

  // checks
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input blocked while output side is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present right after reset");

  a_dir0_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !direction) |-> (real_out == 32'd0 && imag_out == 32'd0))
    else $error("float outputs not cleared in packing direction");

  a_dir1_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction) |-> (packed_out == 32'd0))
    else $error("packed output not cleared in unpacking direction");

endmodule
